### rtl/ssrl_pkg.sv
// ----------------------------------------------------------------------------
// ssrl_pkg: shared types and constants of the servo slew-rate limiter
// Configuration layout, pipeline item and control records, fixed arithmetic
// constants of the rate-to-step scaling.
// ----------------------------------------------------------------------------
package ssrl_pkg;

    // Joints that have an angle input and a limit register
    localparam int NUM_LIMIT_JOINTS = 4;
    // Position fields in a result
    localparam int NUM_OUT_JOINTS = 4;

    localparam logic [7:0] START_DEG = 8'd60;

    // rate * dt never scales beyond 255 degrees
    localparam logic [17:0] PRODUCT_CAP = 18'd255000;
    // Widths of the time and rate-product path
    localparam int DT_W   = 18;
    localparam int PROD_W = 28;

    // prod / 1000 for prod <= PRODUCT_CAP: (prod * DIV_RECIP) >> DIV_SHIFT
    localparam logic [18:0] DIV_RECIP = 19'd268436;
    localparam int          DIV_SHIFT = 28;
    localparam logic [17:0] DIV_BASE  = 18'd1000;
    // Extra fraction bits of the remainder reciprocal
    localparam int REM_SHIFT = 20;

    typedef enum logic {
        FUNC_FRAME = 1'b0,
        FUNC_TIME  = 1'b1
    } func_e;

    typedef enum logic [2:0] {
        REG_MAX_RATE      = 3'd0,
        REG_LINK_TIMEOUT  = 3'd1,
        REG_TICK_PERIOD   = 3'd2,
        REG_BASE_LIMITS   = 3'd3,
        REG_SHLDR_LIMITS  = 3'd4,
        REG_ELBOW_LIMITS  = 3'd5,
        REG_CLAW_LIMITS   = 3'd6
    } cfg_index_e;

    typedef struct packed {
        logic [9:0]                         max_rate_dps;
        logic [15:0]                        frame_timeout_ms;
        logic [7:0]                         tick_period_ms;
        logic [NUM_LIMIT_JOINTS-1:0][15:0]  limits;     // high in 15:8, low in 7:0
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_rate_dps:     10'd120,
        frame_timeout_ms: 16'd500,
        tick_period_ms:   8'd20,
        limits:           {16'hA014, 16'h961E, 16'h961E, 16'hB400}
    };

    typedef struct packed {
        func_e                              func;
        logic [31:0]                        now_ms;
        logic [NUM_LIMIT_JOINTS-1:0][7:0]   angles;
    } item_t;

    // Control record that travels down the pipeline with each item
    typedef struct packed {
        logic                               tick;       // 0: command frame
        logic                               lost;
        logic [NUM_LIMIT_JOINTS-1:0][7:0]   targets;    // clamped frame angles
    } stage_ctrl_t;

    function automatic logic [7:0] clamp_angle(input logic [7:0] v, input logic [15:0] lim);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = lim[7:0];
        hi = lim[15:8];
        if (v < lo) begin
            clamp_angle = lo;
        end else if (v > hi) begin
            clamp_angle = hi;
        end else begin
            clamp_angle = v;
        end
    endfunction

endpackage

### rtl/ssrl_timing.sv
// ----------------------------------------------------------------------------
// ssrl_timing: tick decision and frame bookkeeping
// Holds the last tick and last frame times, decides tick and link loss,
// clamps frame angles and forms the rate * dt product.
// ----------------------------------------------------------------------------
module ssrl_timing
    import ssrl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  item_t               item,
    input  logic                en,
    output logic                keep,
    output stage_ctrl_t         ctrl_reg,
    output logic [PROD_W-1:0]   prod_reg
);

    logic [31:0]        last_tick_reg;
    logic [31:0]        last_frame_reg;
    logic [31:0]        dt;
    logic [31:0]        since_frame;
    logic               is_tick;
    logic               is_lost;
    logic [DT_W-1:0]    dt_cap;
    stage_ctrl_t        ctrl_next;

    always_comb begin
        dt          = item.now_ms - last_tick_reg;
        since_frame = item.now_ms - last_frame_reg;
        is_tick     = (item.func == FUNC_TIME) && (dt >= {24'd0, cfg.tick_period_ms});
        is_lost     = since_frame > {16'd0, cfg.frame_timeout_ms};
        keep        = (item.func == FUNC_FRAME) || is_tick;
        // Saturate dt early: any longer gap hits the product cap anyway
        dt_cap      = (dt > {14'd0, PRODUCT_CAP}) ? PRODUCT_CAP : dt[DT_W-1:0];

        ctrl_next.tick = is_tick;
        ctrl_next.lost = is_lost;
        for (int j = 0; j < NUM_LIMIT_JOINTS; j++) begin
            ctrl_next.targets[j] = clamp_angle(item.angles[j], cfg.limits[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_tick_reg  <= '0;
            last_frame_reg <= '0;
        end else if (en) begin
            if (item.func == FUNC_FRAME) begin
                last_frame_reg <= item.now_ms;
            end
            if (is_tick) begin
                last_tick_reg <= item.now_ms;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_reg <= ctrl_next;
            prod_reg <= PROD_W'(cfg.max_rate_dps) * PROD_W'(dt_cap);
        end
    end

endmodule

### rtl/ssrl_scale.sv
// ----------------------------------------------------------------------------
// ssrl_scale: step size from the rate product
// Three stages form floor(prod * 2^FRAC_BITS / 1000) as whole degrees from a
// reciprocal divide plus a fraction from the remainder.
// ----------------------------------------------------------------------------
module ssrl_scale
    import ssrl_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    aclk,
    input  logic [PROD_W-1:0]       prod,
    input  logic                    en2,
    input  logic                    en3,
    input  logic                    en4,
    output logic [8+FRAC_BITS-1:0]  step_reg
);

    localparam int RECIP_W = FRAC_BITS + 11;
    localparam int QPROD_W = 10 + RECIP_W;
    // ceil(2^(FRAC_BITS+REM_SHIFT) / 1000), exact for remainders below 1000
    localparam logic [RECIP_W-1:0] REM_RECIP =
        RECIP_W'(((64'd1 << (FRAC_BITS + REM_SHIFT)) + 64'd999) / 64'd1000);

    logic [17:0]            capped;
    logic [36:0]            quot_full;
    logic [17:0]            capped_reg;
    logic [7:0]             whole2_reg;
    logic [17:0]            whole_x1000;
    logic [17:0]            rem_full;
    logic [9:0]             rem_reg;
    logic [7:0]             whole3_reg;
    logic [QPROD_W-1:0]     qprod;

    // Stage 2: cap and divide by 1000
    always_comb begin
        capped    = (prod > {10'd0, PRODUCT_CAP}) ? PRODUCT_CAP : prod[17:0];
        quot_full = 37'(capped) * 37'(DIV_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            capped_reg <= capped;
            whole2_reg <= quot_full[DIV_SHIFT +: 8];
        end
    end

    // Stage 3: remainder of the divide
    always_comb begin
        whole_x1000 = 18'(whole2_reg) * DIV_BASE;
        rem_full    = capped_reg - whole_x1000;
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            rem_reg    <= rem_full[9:0];
            whole3_reg <= whole2_reg;
        end
    end

    // Stage 4: remainder scaled to the fraction field
    assign qprod = QPROD_W'(rem_reg) * QPROD_W'(REM_RECIP);

    always_ff @(posedge aclk) begin
        if (en4) begin
            step_reg <= {whole3_reg, qprod[REM_SHIFT +: FRAC_BITS]};
        end
    end

endmodule

### rtl/ssrl_axes.sv
// ----------------------------------------------------------------------------
// ssrl_axes: joint targets, positions and result register
// Applies frames to targets, freezes targets on link loss, slews each
// position by at most one step and registers the rounded positions.
// ----------------------------------------------------------------------------
module ssrl_axes
    import ssrl_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int JOINTS    = 4
)
(
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  stage_ctrl_t                         ctrl,
    input  logic [8+FRAC_BITS-1:0]              step,
    output logic [NUM_OUT_JOINTS-1:0][7:0]      pos_out,
    output logic                                lost_out
);

    localparam int PW = 8 + FRAC_BITS;
    localparam logic [PW-1:0] HALF      = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] START_POS = PW'(START_DEG) << FRAC_BITS;

    function automatic logic [7:0] round_pos(input logic [PW-1:0] p);
        logic [PW:0] sum;
        logic [8:0]  whole;
        sum       = {1'b0, p} + {1'b0, HALF};
        whole     = sum[PW:FRAC_BITS];
        round_pos = whole[8] ? 8'hFF : whole[7:0];
    endfunction

    logic [JOINTS-1:0][7:0]             joint_pos;
    logic [NUM_OUT_JOINTS-1:0][7:0]     out_next;
    logic [NUM_OUT_JOINTS-1:0][7:0]     pos_out_reg;
    logic                               lost_out_reg;

    for (genvar j = 0; j < JOINTS; j++) begin : g_joint
        logic [PW-1:0]  pos_reg;
        logic [PW-1:0]  pos_next;
        logic [PW-1:0]  goal;
        logic [PW-1:0]  gap;
        logic [7:0]     tgt_reg;
        logic [7:0]     tgt_next;
        logic [7:0]     frame_tgt;

        // Joints without an angle input keep their target on a frame
        if (j < NUM_LIMIT_JOINTS) begin : g_cmd
            assign frame_tgt = ctrl.targets[j];
        end else begin : g_nocmd
            assign frame_tgt = tgt_reg;
        end

        always_comb begin
            tgt_next = tgt_reg;
            pos_next = pos_reg;
            goal     = '0;
            gap      = '0;
            if (ctrl.tick) begin
                if (ctrl.lost) begin
                    tgt_next = round_pos(pos_reg);
                end
                goal = PW'(tgt_next) << FRAC_BITS;
                if (goal >= pos_reg) begin
                    gap      = goal - pos_reg;
                    pos_next = (gap > step) ? pos_reg + step : goal;
                end else begin
                    gap      = pos_reg - goal;
                    pos_next = (gap > step) ? pos_reg - step : goal;
                end
            end else begin
                tgt_next = frame_tgt;
            end
        end

        assign joint_pos[j] = round_pos(pos_next);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pos_reg <= START_POS;
                tgt_reg <= START_DEG;
            end else if (en) begin
                pos_reg <= pos_next;
                tgt_reg <= tgt_next;
            end
        end
    end

    for (genvar o = 0; o < NUM_OUT_JOINTS; o++) begin : g_out
        if (o < JOINTS) begin : g_used
            assign out_next[o] = joint_pos[o];
        end else begin : g_unused
            assign out_next[o] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && ctrl.tick) begin
            pos_out_reg  <= out_next;
            lost_out_reg <= ctrl.lost;
        end
    end

    assign pos_out  = pos_out_reg;
    assign lost_out = lost_out_reg;

endmodule

### rtl/servo_slew_rate_limiter.sv
// ----------------------------------------------------------------------------
// servo_slew_rate_limiter: four-joint servo slew-rate limiter
// Clamps commanded joint angles and moves joint positions toward them no
// faster than the configured rate, on time updates at the tick period.
// ----------------------------------------------------------------------------
// A frame transfer (func 0) clamps the four angles to their joint limits,
// stores them as targets and records the frame time; it produces no result.
// A time transfer (func 1) ticks when at least tick_period_ms has passed since
// the last tick; an early one is dropped and changes nothing. Each tick
// returns one result with every position rounded half up to whole degrees
// and link_lost set when no frame arrived within the frame timeout register,
// in which case every target freezes at its current rounded position first.
// The block takes one transfer per clock while s_ready is high. A tick result
// passes a six-register path: input register, tick decision and rate * dt
// multiply, reciprocal divide by 1000, remainder, fraction scaling, and the
// position update with the result register. A result held by a stalled
// m_ready does not block input: s_ready stays high until every pipeline
// stage is full. Configuration writes are taken in any cycle (cfg_ready is
// always high) and must only come while no transfer is in flight; index 7
// is ignored.
// ----------------------------------------------------------------------------
module servo_slew_rate_limiter
    import ssrl_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int JOINTS    = 4
)
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_now_ms,
    input  logic [7:0]  s_base_angle,
    input  logic [7:0]  s_shoulder_angle,
    input  logic [7:0]  s_elbow_angle,
    input  logic [7:0]  s_claw_angle,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_base_pos,
    output logic [7:0]  m_shoulder_pos,
    output logic [7:0]  m_elbow_pos,
    output logic [7:0]  m_claw_pos,
    output logic        m_link_lost
);

    cfg_t                               cfg_reg;
    item_t                              s0_reg;
    logic                               s0_valid_reg;
    logic                               v1_reg;
    logic                               v2_reg;
    logic                               v3_reg;
    logic                               v4_reg;
    logic                               m_valid_reg;
    stage_ctrl_t                        ctrl1_reg;
    stage_ctrl_t                        ctrl2_reg;
    stage_ctrl_t                        ctrl3_reg;
    stage_ctrl_t                        ctrl4_reg;
    logic [PROD_W-1:0]                  prod1_reg;
    logic [8+FRAC_BITS-1:0]             step4_reg;
    logic [NUM_OUT_JOINTS-1:0][7:0]     pos_out;
    logic                               keep1;

    logic   in_xfer;
    logic   rdy_out;
    logic   mv0;
    logic   load1;
    logic   load2;
    logic   load3;
    logic   load4;
    logic   mv4;
    logic   free1;
    logic   free2;
    logic   free3;
    logic   free4;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index_e'(cfg_index))
                REG_MAX_RATE:     cfg_reg.max_rate_dps     <= cfg_data[9:0];
                REG_LINK_TIMEOUT: cfg_reg.frame_timeout_ms <= cfg_data;
                REG_TICK_PERIOD:  cfg_reg.tick_period_ms   <= cfg_data[7:0];
                REG_BASE_LIMITS:  cfg_reg.limits[0]        <= cfg_data;
                REG_SHLDR_LIMITS: cfg_reg.limits[1]        <= cfg_data;
                REG_ELBOW_LIMITS: cfg_reg.limits[2]        <= cfg_data;
                REG_CLAW_LIMITS:  cfg_reg.limits[3]        <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow: each stage advances when the next one is free or
    // leaving. Frames and early time items never occupy the result register.
    // ------------------------------------------------------------------
    always_comb begin
        rdy_out = !m_valid_reg || m_ready;
        mv4     = v4_reg && (!ctrl4_reg.tick || rdy_out);
        free4   = !v4_reg || mv4;
        load4   = v3_reg && free4;
        free3   = !v3_reg || load4;
        load3   = v2_reg && free3;
        free2   = !v2_reg || load3;
        load2   = v1_reg && free2;
        free1   = !v1_reg || load2;
        mv0     = s0_valid_reg && free1;
        // Drop time items that arrive before the tick period is up
        load1   = mv0 && keep1;
        s_ready = !s0_valid_reg || free1;
        in_xfer = s_valid && s_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s0_valid_reg <= in_xfer || (s0_valid_reg && !mv0);
            v1_reg       <= load1 || (v1_reg && !load2);
            v2_reg       <= load2 || (v2_reg && !load3);
            v3_reg       <= load3 || (v3_reg && !load4);
            v4_reg       <= load4 || (v4_reg && !mv4);
            m_valid_reg  <= (mv4 && ctrl4_reg.tick) || (m_valid_reg && !m_ready);
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s0_reg.func      <= func_e'(s_func);
            s0_reg.now_ms    <= s_now_ms;
            s0_reg.angles[0] <= s_base_angle;
            s0_reg.angles[1] <= s_shoulder_angle;
            s0_reg.angles[2] <= s_elbow_angle;
            s0_reg.angles[3] <= s_claw_angle;
        end
    end

    // Carry the control record alongside the step computation
    always_ff @(posedge aclk) begin
        if (load2) begin
            ctrl2_reg <= ctrl1_reg;
        end
        if (load3) begin
            ctrl3_reg <= ctrl2_reg;
        end
        if (load4) begin
            ctrl4_reg <= ctrl3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    ssrl_timing u_timing (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .item     (s0_reg),
        .en       (mv0),
        .keep     (keep1),
        .ctrl_reg (ctrl1_reg),
        .prod_reg (prod1_reg)
    );

    ssrl_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .aclk     (aclk),
        .prod     (prod1_reg),
        .en2      (load2),
        .en3      (load3),
        .en4      (load4),
        .step_reg (step4_reg)
    );

    ssrl_axes #(
        .FRAC_BITS (FRAC_BITS),
        .JOINTS    (JOINTS)
    ) u_axes (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (mv4),
        .ctrl     (ctrl4_reg),
        .step     (step4_reg),
        .pos_out  (pos_out),
        .lost_out (m_link_lost)
    );

    assign m_valid        = m_valid_reg;
    assign m_base_pos     = pos_out[0];
    assign m_shoulder_pos = pos_out[1];
    assign m_elbow_pos    = pos_out[2];
    assign m_claw_pos     = pos_out[3];

endmodule

### rtl/ssrl_checker.sv
// ----------------------------------------------------------------------------
// ssrl_port_checks: port-level checks of the servo slew-rate limiter
// Watches reset, result stalls and input back-pressure.
// ----------------------------------------------------------------------------
module ssrl_port_checks (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_ready,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_base_pos,
    input  logic [7:0]  m_shoulder_pos,
    input  logic [7:0]  m_elbow_pos,
    input  logic [7:0]  m_claw_pos,
    input  logic        m_link_lost
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled result unchanged
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_base_pos)
            && $stable(m_shoulder_pos) && $stable(m_elbow_pos)
            && $stable(m_claw_pos) && $stable(m_link_lost))
        else $error("stalled result changed");

    // With the result side free, every stage drains, so input is never held off
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while result side is free");

endmodule

bind servo_slew_rate_limiter ssrl_port_checks u_checker (.*);
